FILE: rtl/dbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbd_pkg
// Shared types, constants and the tag classifier of the block deframer.
// ----------------------------------------------------------------------------
package dbd_pkg;

  localparam int MAX_AREA_BYTES = 256;
  localparam int MAX_BLOCKS     = 64;

  localparam logic [8:0] MAX_AREA = 9'(MAX_AREA_BYTES);
  localparam logic [6:0] MAX_BLK  = 7'(MAX_BLOCKS);

  // configuration register indexes
  localparam logic [3:0] CFG_AREA_LENGTH = 4'd0;
  localparam logic [3:0] CFG_BLOCK_LIMIT = 4'd1;

  localparam logic [8:0] AREA_LENGTH_RST = 9'd256;
  localparam logic [6:0] BLOCK_LIMIT_RST = 7'd64;

  // tags
  localparam logic [7:0] TAG_PADDING    = 8'd0;
  localparam logic [7:0] TAG_V1_LAST    = 8'd19;
  localparam logic [7:0] TAG_TILED_V1   = 8'd18;
  localparam logic [7:0] TAG_V2_FIRST   = 8'd32;
  localparam logic [7:0] TAG_V2_LAST    = 8'd41;
  localparam logic [7:0] TAG_TILED_V2   = 8'd40;
  localparam logic [7:0] TAG_VENDOR_V1  = 8'd127;
  localparam logic [7:0] TAG_VENDOR_V2  = 8'd126;
  localparam logic [7:0] TAG_CTA        = 8'd129;
  localparam logic [8:0] TILED_MIN_SIZE = 9'd25;
  localparam logic [8:0] HEADER_BYTES   = 9'd3;

  // classes
  localparam logic [5:0] CLASS_VENDOR_V1 = 6'd21;
  localparam logic [5:0] CLASS_VENDOR_V2 = 6'd32;
  localparam logic [5:0] CLASS_CTA       = 6'd33;
  localparam logic [5:0] CLASS_OTHER     = 6'd34;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int MAX_PUSH   = 3;

  typedef enum logic [1:0] {
    PH_TAG,
    PH_REV,
    PH_SIZE,
    PH_PAYLOAD
  } phase_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [5:0] block_number;
    logic [7:0] offset_in_block;
    logic [5:0] block_class;
    logic       block_end;
    logic [8:0] stored_total;
  } result_t;

  typedef struct packed {
    logic [1:0]            count;
    result_t [MAX_PUSH-1:0] item;
  } push_t;

  typedef struct packed {
    logic                  room;
    logic [FIFO_CNT_W-1:0] count;
  } fifo_stat_t;

  function automatic logic [5:0] tag_class(input logic [7:0] tag, input logic [8:0] total);
    logic [5:0] c;
    c = CLASS_OTHER;
    if (tag <= TAG_V1_LAST) begin
      if (tag == TAG_TILED_V1 && total < TILED_MIN_SIZE) c = CLASS_OTHER;
      else c = 6'(tag + 8'd1);
    end else if (tag >= TAG_V2_FIRST && tag <= TAG_V2_LAST) begin
      if (tag == TAG_TILED_V2 && total < TILED_MIN_SIZE) c = CLASS_OTHER;
      else c = 6'(tag - 8'd10);
    end else if (tag == TAG_VENDOR_V1) begin
      c = CLASS_VENDOR_V1;
    end else if (tag == TAG_VENDOR_V2) begin
      c = CLASS_VENDOR_V2;
    end else if (tag == TAG_CTA) begin
      c = CLASS_CTA;
    end
    return c;
  endfunction

endpackage

FILE: rtl/dbd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbd_in_if
// Input byte channel: one area byte and the start-of-area flag per item.
// ----------------------------------------------------------------------------
interface dbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_area;

  modport source(output valid, data_byte, start_of_area, input ready);
  modport sink(input valid, data_byte, start_of_area, output ready);
endinterface

FILE: rtl/dbd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbd_out_if
// Result channel: one block byte with its block position and totals.
// ----------------------------------------------------------------------------
interface dbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [5:0] block_number;
  logic [7:0] offset_in_block;
  logic [5:0] block_class;
  logic       block_end;
  logic [8:0] stored_total;

  modport source(output valid, out_byte, block_number, offset_in_block, block_class,
                 block_end, stored_total, input ready);
  modport sink(input valid, out_byte, block_number, offset_in_block, block_class,
               block_end, stored_total, output ready);
endinterface

FILE: rtl/dbd_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface dbd_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] index;
  logic [8:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/dbd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbd_parser
// Input register, configuration registers and the single-pass header /
// payload parser that turns one byte into zero, one or three results.
// ----------------------------------------------------------------------------
module dbd_parser import dbd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  dbd_cfg_if.sink   cfg,
  dbd_in_if.sink    in,
  input  logic      room_i,
  output push_t     push_o
);

  logic [8:0] area_length_q;
  logic [6:0] block_limit_q;

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_start_q;
  logic       advance;

  logic [8:0] pos_q, pos_d, eff_pos;
  phase_e     phase_q, phase_d, eff_phase;
  logic [7:0] tag_q, tag_d, eff_tag;
  logic [7:0] rev_q, rev_d, eff_rev;
  logic [7:0] left_q, left_d, eff_left;
  logic [5:0] class_q, class_d, eff_class;
  logic [7:0] off_q, off_d, eff_off;
  logic [6:0] blocks_q, blocks_d, eff_blocks;
  logic [8:0] bytes_q, bytes_d, eff_bytes;

  logic [8:0] area, left9, total, bytes_new;
  logic [6:0] lim;
  logic [7:0] size;
  logic [5:0] cls_new;
  logic [1:0] push_cnt;
  result_t [MAX_PUSH-1:0] items;

  assign cfg.ready = 1'b1;
  assign advance   = s1_valid_q && room_i;
  assign in.ready  = !s1_valid_q || room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_length_q <= AREA_LENGTH_RST;
      block_limit_q <= BLOCK_LIMIT_RST;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_AREA_LENGTH) area_length_q <= cfg.data;
      else if (cfg.index == CFG_BLOCK_LIMIT) block_limit_q <= cfg.data[6:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in.ready) begin
      s1_valid_q <= in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in.ready && in.valid) begin
      s1_byte_q  <= in.data_byte;
      s1_start_q <= in.start_of_area;
    end
  end

  always_comb begin
    // start of area clears the parser before the byte is taken
    eff_pos    = s1_start_q ? '0 : pos_q;
    eff_phase  = s1_start_q ? PH_TAG : phase_q;
    eff_tag    = s1_start_q ? '0 : tag_q;
    eff_rev    = s1_start_q ? '0 : rev_q;
    eff_left   = s1_start_q ? '0 : left_q;
    eff_class  = s1_start_q ? CLASS_OTHER : class_q;
    eff_off    = s1_start_q ? '0 : off_q;
    eff_blocks = s1_start_q ? '0 : blocks_q;
    eff_bytes  = s1_start_q ? '0 : bytes_q;

    area      = (area_length_q > MAX_AREA) ? MAX_AREA : area_length_q;
    lim       = (block_limit_q > MAX_BLK) ? MAX_BLK : block_limit_q;
    left9     = area - eff_pos - 9'd1;
    size      = ({1'b0, s1_byte_q} > left9) ? left9[7:0] : s1_byte_q;
    total     = {1'b0, size} + HEADER_BYTES;
    cls_new   = tag_class(eff_tag, total);
    bytes_new = eff_bytes + total;

    pos_d    = (eff_pos < MAX_AREA) ? eff_pos + 9'd1 : eff_pos;
    phase_d  = eff_phase;
    tag_d    = eff_tag;
    rev_d    = eff_rev;
    left_d   = eff_left;
    class_d  = eff_class;
    off_d    = eff_off;
    blocks_d = eff_blocks;
    bytes_d  = eff_bytes;
    push_cnt = 2'd0;
    items    = '0;

    if (eff_pos < area) begin
      unique case (eff_phase)
        PH_TAG: begin
          if (eff_blocks < lim) begin
            tag_d   = s1_byte_q;
            phase_d = PH_REV;
          end
        end
        PH_REV: begin
          rev_d   = s1_byte_q;
          phase_d = PH_SIZE;
        end
        PH_SIZE: begin
          phase_d = PH_TAG;
          // zero-size padding blocks and blocks over the limit are dropped
          if (!(eff_tag == TAG_PADDING && size == 8'd0) && eff_blocks < lim) begin
            class_d  = cls_new;
            bytes_d  = bytes_new;
            blocks_d = eff_blocks + 7'd1;
            left_d   = size;
            off_d    = 8'd3;
            phase_d  = (size != 8'd0) ? PH_PAYLOAD : PH_TAG;
            push_cnt = 2'd3;
            items[0] = '{out_byte: eff_tag, block_number: eff_blocks[5:0],
                         offset_in_block: 8'd0, block_class: cls_new,
                         block_end: 1'b0, stored_total: bytes_new};
            items[1] = '{out_byte: eff_rev, block_number: eff_blocks[5:0],
                         offset_in_block: 8'd1, block_class: cls_new,
                         block_end: 1'b0, stored_total: bytes_new};
            items[2] = '{out_byte: size, block_number: eff_blocks[5:0],
                         offset_in_block: 8'd2, block_class: cls_new,
                         block_end: (size == 8'd0), stored_total: bytes_new};
          end
        end
        PH_PAYLOAD: begin
          if (eff_left == 8'd0 || eff_blocks == 7'd0) begin
            phase_d = PH_TAG;
          end else begin
            push_cnt = 2'd1;
            items[0] = '{out_byte: s1_byte_q, block_number: 6'(eff_blocks - 7'd1),
                         offset_in_block: eff_off, block_class: eff_class,
                         block_end: (eff_left == 8'd1), stored_total: eff_bytes};
            left_d   = eff_left - 8'd1;
            off_d    = eff_off + 8'd1;
            if (eff_left == 8'd1) phase_d = PH_TAG;
          end
        end
      endcase
    end

    push_o.count = advance ? push_cnt : 2'd0;
    push_o.item  = items;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      phase_q  <= PH_TAG;
      tag_q    <= '0;
      rev_q    <= '0;
      left_q   <= '0;
      class_q  <= CLASS_OTHER;
      off_q    <= '0;
      blocks_q <= '0;
      bytes_q  <= '0;
    end else if (advance) begin
      pos_q    <= pos_d;
      phase_q  <= phase_d;
      tag_q    <= tag_d;
      rev_q    <= rev_d;
      left_q   <= left_d;
      class_q  <= class_d;
      off_q    <= off_d;
      blocks_q <= blocks_d;
      bytes_q  <= bytes_d;
    end
  end

endmodule

FILE: rtl/dbd_result_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbd_result_fifo
// Result queue: takes up to three results per cycle, hands out one per cycle while out.ready is high.
// ----------------------------------------------------------------------------
module dbd_result_fifo import dbd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  push_t      push_i,
  output fifo_stat_t stat_o,
  dbd_out_if.source  out
);

  result_t [FIFO_DEPTH-1:0] mem_q;
  logic [FIFO_PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0]    count_q, count_d;
  logic                     pop;
  result_t                  head;

  assign head      = mem_q[rd_ptr_q];
  assign out.valid = (count_q != '0);
  assign pop       = out.valid && out.ready;

  assign out.out_byte        = head.out_byte;
  assign out.block_number    = head.block_number;
  assign out.offset_in_block = head.offset_in_block;
  assign out.block_class     = head.block_class;
  assign out.block_end       = head.block_end;
  assign out.stored_total    = head.stored_total;

  // room for a full header burst, regardless of this cycle's pop
  assign stat_o.room  = (count_q <= FIFO_CNT_W'(FIFO_DEPTH - MAX_PUSH));
  assign stat_o.count = count_q;

  assign count_d = count_q + FIFO_CNT_W'(push_i.count) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_PUSH; k++) begin
      if (2'(k) < push_i.count) begin
        mem_q[wr_ptr_q + FIFO_PTR_W'(k)] <= push_i.item[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push_i.count);
      rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(pop);
      count_q  <= count_d;
    end
  end

endmodule

FILE: rtl/displayid_block_deframer.sv
`timescale 1ns / 1ps
// Path: an accepted byte waits in the input register while the queue lacks room.
// Throughput: one byte per cycle while the queue holds at most five results;
//   a size byte yields three results, which an 8-entry result queue drains
//   at one per cycle while out_o is ready.
// Reset: rst_ni asynchronous, active low; clears parser and queue, sets
//   area_length to 256 and block_limit to 64. No clearing pass.
// ----------------------------------------------------------------------------
// displayid_block_deframer
// DisplayID data-block deframer: header/payload parse with a result queue.
// ----------------------------------------------------------------------------
module displayid_block_deframer import dbd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  dbd_cfg_if.sink   cfg_i,
  dbd_in_if.sink    in_i,
  dbd_out_if.source out_o
);

  push_t      push;
  fifo_stat_t stat;

  dbd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_i),
    .in     (in_i),
    .room_i (stat.room),
    .push_o (push)
  );

  dbd_result_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .stat_o (stat),
    .out    (out_o)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.count != 2'd0) |-> stat.room)
    else $error("push without room");

  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.count != 2'd0) |=> out_o.valid)
    else $error("pushed result not visible");
`endif

endmodule

FILE: verif/tb_displayid_block_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_displayid_block_deframer
// Self-checking bench for the DisplayID block deframer. Streams data-block
// areas byte by byte, predicts emitted block bytes in a local parser model
// or a directed table and checks each result on the output channel. Covers a short table
// of directed bytes, then random well-formed and broken areas under several
// area-length / block-limit settings and varying backpressure.
// ----------------------------------------------------------------------------
module tb_displayid_block_deframer;
  import dbd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_GAP   = 16;
  localparam int HOLD_CYCLES = 120;

  typedef enum {ROW_MODEL, ROW_NONE, ROW_ONE} row_kind_e;

  typedef struct {
    logic       sa;
    logic [7:0] b;
    row_kind_e  kind;
    result_t    want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dbd_cfg_if cfg_if();
  dbd_in_if  in_if();
  dbd_out_if out_if();

  displayid_block_deframer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // parser model state
  logic [8:0] area_cfg;
  logic [6:0] limit_cfg;
  logic [8:0] area_pos;
  phase_e     parse_ph;
  logic [7:0] tag_hold;
  logic [7:0] rev_hold;
  logic [7:0] payload_rem;
  logic [5:0] class_now;
  logic [7:0] offset_now;
  logic [6:0] blocks_seen;
  logic [8:0] total_bytes;

  result_t expected_bytes[$];
  result_t step_out[$];
  row_t    dir_tab[$];

  int errors = 0;
  int items_sent = 0;
  int areas_sent = 0;
  int results_checked = 0;
  int snd_pct = 21;
  int rcv_pct = 58;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_cnt = 0;

  task automatic flag_error(string msg);
    errors++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function automatic string show(result_t r);
    return $sformatf("byte %02h blk %0d off %0d cls %0d end %0d tot %0d", r.out_byte,
                     r.block_number, r.offset_in_block, r.block_class, r.block_end,
                     r.stored_total);
  endfunction

  function automatic void restart_area();
    area_pos    = '0;
    parse_ph    = PH_TAG;
    tag_hold    = '0;
    rev_hold    = '0;
    payload_rem = '0;
    class_now   = CLASS_OTHER;
    offset_now  = '0;
    blocks_seen = '0;
    total_bytes = '0;
  endfunction

  function automatic logic [5:0] tag_group(logic [7:0] tag, int total);
    logic [5:0] c;
    c = CLASS_OTHER;
    if (tag <= TAG_V1_LAST) c = 6'(tag + 8'd1);
    else if (tag >= TAG_V2_FIRST && tag <= TAG_V2_LAST) c = 6'(tag - 8'd10);
    else if (tag == TAG_VENDOR_V1) c = CLASS_VENDOR_V1;
    else if (tag == TAG_VENDOR_V2) c = CLASS_VENDOR_V2;
    else if (tag == TAG_CTA) c = CLASS_CTA;
    // tiled topology needs a full-size block
    if ((tag == TAG_TILED_V1 || tag == TAG_TILED_V2) && total < int'(TILED_MIN_SIZE))
      c = CLASS_OTHER;
    return c;
  endfunction

  function automatic result_t blk_res(logic [7:0] v, int num, int off, int cls, bit fin,
                                      int tot);
    result_t r;
    r.out_byte        = v;
    r.block_number    = 6'(num);
    r.offset_in_block = 8'(off);
    r.block_class     = 6'(cls);
    r.block_end       = fin;
    r.stored_total    = 9'(tot);
    return r;
  endfunction

  // one input byte through the parser; results land in step_out
  function automatic void deframe_byte(logic sa, logic [7:0] b);
    int p, area, lim, left, size;
    step_out.delete();
    if (sa) restart_area();
    p = int'(area_pos);
    if (area_pos < MAX_AREA_BYTES) area_pos++;
    area = (area_cfg > MAX_AREA_BYTES) ? MAX_AREA_BYTES : int'(area_cfg);
    lim  = (limit_cfg > MAX_BLOCKS) ? MAX_BLOCKS : int'(limit_cfg);
    if (p >= area) return;
    case (parse_ph)
      PH_TAG: begin
        if (blocks_seen < lim) begin
          tag_hold = b;
          parse_ph = PH_REV;
        end
      end
      PH_REV: begin
        rev_hold = b;
        parse_ph = PH_SIZE;
      end
      PH_SIZE: begin
        parse_ph = PH_TAG;
        left = area - (p + 1);
        size = (int'(b) > left) ? left : int'(b);
        if (!(tag_hold == TAG_PADDING && size == 0) && blocks_seen < lim) begin
          class_now   = tag_group(tag_hold, size + 3);
          total_bytes = 9'(int'(total_bytes) + size + 3);
          step_out.push_back(blk_res(tag_hold, blocks_seen, 0, class_now, 0, total_bytes));
          step_out.push_back(blk_res(rev_hold, blocks_seen, 1, class_now, 0, total_bytes));
          step_out.push_back(blk_res(8'(size), blocks_seen, 2, class_now, size == 0,
                                     total_bytes));
          blocks_seen++;
          payload_rem = 8'(size);
          offset_now  = 8'd3;
          parse_ph    = (size != 0) ? PH_PAYLOAD : PH_TAG;
        end
      end
      default: begin
        if (payload_rem == 0 || blocks_seen == 0) begin
          parse_ph = PH_TAG;
        end else begin
          step_out.push_back(blk_res(b, blocks_seen - 1, offset_now, class_now,
                                     payload_rem == 1, total_bytes));
          payload_rem--;
          offset_now++;
          if (payload_rem == 0) parse_ph = PH_TAG;
        end
      end
    endcase
  endfunction

  function automatic row_t dir_row(logic sa, logic [7:0] b, row_kind_e kind,
                                   result_t want = '0);
    row_t r;
    r.sa   = sa;
    r.b    = b;
    r.kind = kind;
    r.want = want;
    return r;
  endfunction

  function automatic bit stray();
    return $urandom_range(63) == 0;
  endfunction

  task automatic send_item(logic sa, logic [7:0] b, row_kind_e kind = ROW_MODEL,
                           result_t want = '0);
    if (items_sent < 110) begin
      snd_pct = 21;
      rcv_pct = 58;
    end else if (items_sent < 220) begin
      snd_pct = 58;
      rcv_pct = 21;
    end else begin
      snd_pct = 0;
      rcv_pct = 0;
    end
    while ($urandom_range(99) < snd_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.data_byte     <= b;
    in_if.start_of_area <= sa;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    items_sent++;
    deframe_byte(sa, b);
    case (kind)
      ROW_MODEL: foreach (step_out[i]) expected_bytes.push_back(step_out[i]);
      ROW_ONE:   expected_bytes.push_back(want);
      default:   ;
    endcase
  endtask

  task automatic write_reg(logic [3:0] idx, logic [8:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    if (idx == CFG_AREA_LENGTH) area_cfg = val;
    else if (idx == CFG_BLOCK_LIMIT) limit_cfg = val[6:0];
  endtask

  task automatic set_config(logic [8:0] area, logic [8:0] lim);
    write_reg(CFG_AREA_LENGTH, area);
    write_reg(CFG_BLOCK_LIMIT, lim);
    cfg_if.valid <= 1'b0;
  endtask

  // let every predicted result come out, then give silent bytes time to pass
  task automatic drain();
    in_if.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  task automatic send_area(int n_blocks, int size_max);
    logic [7:0] tag, sz;
    int pick, n_pay;
    areas_sent++;
    for (int k = 0; k < n_blocks; k++) begin
      pick = $urandom_range(7);
      case (pick)
        0: tag = 8'($urandom_range(19));
        1: tag = 8'($urandom_range(41, 32));
        2: tag = $urandom_range(1) ? TAG_TILED_V1 : TAG_TILED_V2;
        3: begin
          case ($urandom_range(2))
            0:       tag = TAG_VENDOR_V1;
            1:       tag = TAG_VENDOR_V2;
            default: tag = TAG_CTA;
          endcase
        end
        4: tag = 8'($urandom_range(255));
        5: tag = TAG_PADDING;
        default: tag = 8'($urandom_range(41));
      endcase
      sz = 8'($urandom_range(size_max));
      n_pay = sz;
      if (pick == 2) begin
        sz = 8'($urandom_range(26, 19));    // straddles the tiled minimum
        n_pay = sz;
      end else if (pick == 5 && $urandom_range(1)) begin
        sz = 8'd0;
        n_pay = 0;
      end else if ($urandom_range(15) == 0) begin
        sz = 8'($urandom_range(255));       // gets clamped to the area end
        n_pay = $urandom_range(4);
      end
      if ($urandom_range(11) == 0) n_pay = $urandom_range(n_pay + 2);
      send_item(k == 0, tag);
      send_item(stray(), 8'($urandom));
      send_item(stray(), sz);
      repeat (n_pay) send_item(stray(), 8'($urandom));
    end
  endtask

  // receiver: random ready, or a long hold when one is requested
  always @(posedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rcv_pct);
    end
  end

  always @(posedge clk_i) begin : check_result
    result_t got, want;
    string diffs;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.out_byte        = out_if.out_byte;
      got.block_number    = out_if.block_number;
      got.offset_in_block = out_if.offset_in_block;
      got.block_class     = out_if.block_class;
      got.block_end       = out_if.block_end;
      got.stored_total    = out_if.stored_total;
      if (expected_bytes.size() == 0) begin
        flag_error($sformatf("unexpected result: %s", show(got)));
      end else begin
        want = expected_bytes.pop_front();
        diffs = "";
        if (got.out_byte !== want.out_byte) diffs = {diffs, " out_byte"};
        if (got.block_number !== want.block_number) diffs = {diffs, " block_number"};
        if (got.offset_in_block !== want.offset_in_block) diffs = {diffs, " offset"};
        if (got.block_class !== want.block_class) diffs = {diffs, " block_class"};
        if (got.block_end !== want.block_end) diffs = {diffs, " block_end"};
        if (got.stored_total !== want.stored_total) diffs = {diffs, " stored_total"};
        if (diffs != "")
          flag_error($sformatf("result %0d wrong in%s: got %s, want %s", results_checked,
                               diffs, show(got), show(want)));
      end
      results_checked++;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_bytes.size());
      $display("displayid_block_deframer: mismatch");
      $finish;
    end
  end

  initial begin
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.data_byte     = '0;
    in_if.start_of_area = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = '0;
    cfg_if.data         = '0;
    out_if.ready        = 1'b0;
    area_cfg            = AREA_LENGTH_RST;
    limit_cfg           = BLOCK_LIMIT_RST;
    restart_area();

    // directed bytes at reset settings; typed results where obvious
    dir_tab.push_back(dir_row(1'b1, 8'h02, ROW_NONE));
    dir_tab.push_back(dir_row(1'b0, 8'hFF, ROW_NONE));
    dir_tab.push_back(dir_row(1'b0, 8'h02, ROW_MODEL));
    dir_tab.push_back(dir_row(1'b0, 8'h00, ROW_ONE, blk_res(8'h00, 0, 3, 3, 0, 5)));
    dir_tab.push_back(dir_row(1'b0, 8'hFF, ROW_ONE, blk_res(8'hFF, 0, 4, 3, 1, 5)));
    // padding block is dropped
    dir_tab.push_back(dir_row(1'b0, TAG_PADDING, ROW_NONE));
    dir_tab.push_back(dir_row(1'b0, 8'h00, ROW_NONE));
    dir_tab.push_back(dir_row(1'b0, 8'h00, ROW_NONE));
    // short tiled blocks fall back to class other; zero size ends on size byte
    dir_tab.push_back(dir_row(1'b0, TAG_TILED_V1, ROW_NONE));
    dir_tab.push_back(dir_row(1'b0, 8'h55, ROW_NONE));
    dir_tab.push_back(dir_row(1'b0, 8'h00, ROW_MODEL));
    dir_tab.push_back(dir_row(1'b0, TAG_TILED_V2, ROW_NONE));
    dir_tab.push_back(dir_row(1'b0, 8'hAA, ROW_NONE));
    dir_tab.push_back(dir_row(1'b0, 8'h01, ROW_MODEL));
    dir_tab.push_back(dir_row(1'b0, 8'h80, ROW_ONE,
                              blk_res(8'h80, 2, 3, CLASS_OTHER, 1, 12)));
    dir_tab.push_back(dir_row(1'b0, TAG_VENDOR_V1, ROW_NONE));
    dir_tab.push_back(dir_row(1'b0, 8'h01, ROW_NONE));
    dir_tab.push_back(dir_row(1'b0, 8'h00, ROW_MODEL));
    dir_tab.push_back(dir_row(1'b0, TAG_CTA, ROW_NONE));
    dir_tab.push_back(dir_row(1'b0, 8'h00, ROW_NONE));
    dir_tab.push_back(dir_row(1'b0, 8'h00, ROW_MODEL));
    dir_tab.push_back(dir_row(1'b0, TAG_VENDOR_V2, ROW_NONE));
    dir_tab.push_back(dir_row(1'b0, 8'h02, ROW_NONE));
    dir_tab.push_back(dir_row(1'b0, 8'h01, ROW_MODEL));
    dir_tab.push_back(dir_row(1'b0, 8'hC3, ROW_ONE,
                              blk_res(8'hC3, 5, 3, CLASS_VENDOR_V2, 1, 22)));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_item(dir_tab[i].sa, dir_tab[i].b, dir_tab[i].kind,
                                   dir_tab[i].want);
    drain();

    set_config(9'd256, 9'd64);
    while (items_sent < 60) send_area($urandom_range(6, 2), 6);
    drain();

    // small area and block limit
    set_config(9'd40, 9'd3);
    while (items_sent < 95) send_area($urandom_range(6, 2), 8);
    drain();

    // empty area, then one that cuts headers
    set_config(9'd0, 9'd64);
    send_area(2, 4);
    drain();
    set_config(9'd7, 9'd64);
    repeat (3) send_area(2, 3);
    drain();

    // register values above the build maximum; receiver holds off meanwhile
    set_config(9'd511, 9'd127);
    hold_reqs++;
    while (items_sent < 165) send_area($urandom_range(5, 2), 5);
    drain();

    set_config(9'd20, 9'd0);
    send_area(3, 4);
    drain();

    set_config(9'd256, 9'd1);
    while (items_sent < 195) send_area($urandom_range(4, 2), 4);
    drain();

    // area shrinks in the middle of a payload and later grows again
    set_config(9'd100, 9'd64);
    send_item(1'b1, 8'h05);
    send_item(1'b0, 8'h01);
    send_item(1'b0, 8'd10);
    repeat (3) send_item(1'b0, 8'($urandom));
    drain();
    set_config(9'd7, 9'd64);
    repeat (3) send_item(1'b0, 8'($urandom));
    drain();
    set_config(9'd100, 9'd64);
    repeat (8) send_item(1'b0, 8'($urandom));
    drain();

    // one long block clamped to the area, with bytes past the end
    set_config(9'd48, 9'd64);
    send_item(1'b1, TAG_V2_FIRST);
    send_item(1'b0, 8'($urandom));
    send_item(1'b0, 8'hFF);
    repeat (47) send_item(1'b0, 8'($urandom));
    drain();

    set_config(9'd256, 9'd64);
    while (items_sent < 270) send_area($urandom_range(6, 2), 6);
    drain();

    $display("sent %0d bytes in %0d random areas plus directed rows; %0d results checked",
             items_sent, areas_sent, results_checked);
    $display("areas 0..511 and block limits 0..127, mid-block area change, long hold-off");
    if (errors == 0) begin
      $display("displayid_block_deframer: match");
    end else begin
      $display("%0d errors", errors);
      $display("displayid_block_deframer: mismatch");
    end
    $finish;
  end

endmodule
